// ===== rtl/core/rwh_pkg.sv =====
// shared types, tag constants and a helper for the riff/wave header parser
package rwh_pkg;

  localparam logic [31:0] TAG_RIFF         = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE         = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT          = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA         = 32'h6174_6164;
  localparam logic [31:0] FMT_BODY_LEN     = 32'd16;
  localparam logic [31:0] DEFAULT_RATE     = 32'd44100;
  localparam logic [15:0] DEFAULT_CHANNELS = 16'd2;

  // byte index positions inside the header, chunk header and fmt body
  localparam logic [3:0] IDX_RIFF_LAST = 4'd3;
  localparam logic [3:0] IDX_WAVE_LOW  = 4'd8;
  localparam logic [3:0] IDX_HEAD_LAST = 4'd11;
  localparam logic [3:0] IDX_TAG_LAST  = 4'd3;
  localparam logic [3:0] IDX_CHDR_LAST = 4'd7;
  localparam logic [3:0] IDX_CH_LO     = 4'd2;
  localparam logic [3:0] IDX_CH_HI     = 4'd3;
  localparam logic [3:0] IDX_RATE_LO   = 4'd4;
  localparam logic [3:0] IDX_RATE_HI   = 4'd7;
  localparam logic [3:0] IDX_FMT_LAST  = 4'd15;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HEAD = 3'd1,
    PH_CHDR = 3'd2,
    PH_FMT  = 3'd3,
    PH_SKIP = 3'd4,
    PH_DONE = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_DATA_FOUND = 2'd0,
    ST_BAD_SIG    = 2'd1,
    ST_EARLY_END  = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
    logic       end_of_file;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [31:0] data_offset;
    logic [31:0] data_size;
  } result_t;

  // replace one byte lane of a little-endian word
  function automatic logic [31:0] set_lane(input logic [31:0] w, input logic [1:0] lane,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = w;
    r[{lane, 3'b000} +: 8] = b;
    return r;
  endfunction

endpackage

// ===== rtl/core/riff_wave_header_parser.sv =====
// top level of the riff/wave header parser: input register, parser, result register
//
// usage
//   input channel: one file byte per item on in_data_byte, with in_start_of_file
//   on the first byte of a file and in_end_of_file on the last available byte
//   result channel: at most one item per file, carrying out_status (data chunk
//   found, bad signature, early end) plus channels, sample rate, data offset
//   and data size; error items carry zeros in all numeric fields
// timing
//   an accepted byte is parsed straight out of the input register once the
//   result register has room, and its result, if any, is loaded there at the
//   edge that retires the byte; one byte per cycle sustained while the result
//   register has room; the parse state loop (phase, byte index, 32-bit
//   position counter and skip counter) closes through combinational logic
// reset
//   rst_n low clears both registers' valid flags and parks the parser idle;
//   bytes before the first start-of-file byte are taken and dropped
// back pressure
//   while out_stall holds a waiting result, the parser takes no byte, since
//   the result register has no room; the input register fills and in_stall
//   rises, so nothing is lost and nothing is repeated
module riff_wave_header_parser
  import rwh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_file,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_channels,
  output logic [31:0] out_sample_rate,
  output logic [31:0] out_data_offset,
  output logic [31:0] out_data_size
);

  item_t   in_item;
  item_t   hold_item;
  logic    hold_valid;
  logic    out_free;
  logic    step;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item = '{data_byte: in_data_byte, start_of_file: in_start_of_file,
                     end_of_file: in_end_of_file};

  // a held byte is parsed only when its possible result has a place to go
  assign step = hold_valid && out_free;

  rwh_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (step),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  rwh_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (hold_item),
    .res_valid (res_valid),
    .res       (res)
  );

  rwh_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res_valid),
    .load_res  (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .free      (out_free),
    .out_res   (out_res)
  );

  // unpack the result item onto its field ports
  assign out_status      = out_res.status;
  assign out_channels    = out_res.channels;
  assign out_sample_rate = out_res.sample_rate;
  assign out_data_offset = out_res.data_offset;
  assign out_data_size   = out_res.data_size;

endmodule

// ===== rtl/core/rwh_in_reg.sv =====
// input register stage holding one byte item until the parser takes it
module rwh_in_reg
  import rwh_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  take,
  output logic  hold_valid,
  output item_t hold_item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  accept;

  assign in_stall   = valid_r && !take;
  assign accept     = in_valid && !in_stall;
  assign hold_valid = valid_r;
  assign hold_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b0;
    end
    if (accept) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== rtl/core/rwh_parse.sv =====
// parse state machine: one byte per step, header checks, chunk walk, result build
module rwh_parse
  import rwh_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  output logic    res_valid,
  output result_t res
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [15:0] ch_r, ch_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic        bad_r, bad_nxt;

  // state after an optional restart
  phase_t      ph_s;
  logic [3:0]  idx_s;
  logic [31:0] pos_s, tag_s, len_s, skip_s, rate_s;
  logic [15:0] ch_s;
  logic        bad_s;
  logic [7:0]  b;
  logic [31:0] skip_dec;

  always_comb begin
    b = item.data_byte;
    if (item.start_of_file) begin
      ph_s   = PH_HEAD;
      idx_s  = '0;
      pos_s  = '0;
      tag_s  = '0;
      len_s  = '0;
      skip_s = '0;
      ch_s   = DEFAULT_CHANNELS;
      rate_s = DEFAULT_RATE;
      bad_s  = 1'b0;
    end else begin
      ph_s   = phase_r;
      idx_s  = idx_r;
      pos_s  = pos_r;
      tag_s  = tag_r;
      len_s  = len_r;
      skip_s = skip_r;
      ch_s   = ch_r;
      rate_s = rate_r;
      bad_s  = bad_r;
    end

    phase_nxt = ph_s;
    idx_nxt   = idx_s;
    pos_nxt   = pos_s;
    tag_nxt   = tag_s;
    len_nxt   = len_s;
    skip_nxt  = skip_s;
    ch_nxt    = ch_s;
    rate_nxt  = rate_s;
    bad_nxt   = bad_s;
    res_valid = 1'b0;
    res       = '{status: ST_DATA_FOUND, channels: '0, sample_rate: '0,
                  data_offset: '0, data_size: '0};
    skip_dec  = skip_s - 32'd1;

    if (step && ph_s != PH_IDLE && ph_s != PH_DONE) begin
      if (pos_s != '1) begin
        pos_nxt = pos_s + 32'd1;
      end
      case (ph_s)
        PH_HEAD: begin
          if (idx_s < 4'd4 || idx_s >= IDX_WAVE_LOW) begin
            tag_nxt = set_lane(tag_s, idx_s[1:0], b);
          end
          if (idx_s == IDX_RIFF_LAST) begin
            if (tag_nxt != TAG_RIFF) begin
              bad_nxt = 1'b1;
            end
            tag_nxt = '0;
          end
          if (idx_s >= IDX_HEAD_LAST) begin
            if (tag_nxt != TAG_WAVE) begin
              bad_nxt = 1'b1;
            end
            tag_nxt = '0;
            idx_nxt = '0;
            if (bad_nxt) begin
              res_valid  = 1'b1;
              res.status = ST_BAD_SIG;
              phase_nxt  = PH_DONE;
            end else begin
              phase_nxt = PH_CHDR;
            end
          end else begin
            idx_nxt = idx_s + 4'd1;
          end
        end
        PH_CHDR: begin
          if (idx_s <= IDX_TAG_LAST) begin
            tag_nxt = set_lane((idx_s == '0) ? '0 : tag_s, idx_s[1:0], b);
          end else begin
            len_nxt = set_lane((idx_s == 4'd4) ? '0 : len_s, idx_s[1:0], b);
          end
          if (idx_s >= IDX_CHDR_LAST) begin
            idx_nxt = '0;
            if (tag_nxt == TAG_FMT) begin
              phase_nxt = PH_FMT;
            end else if (tag_nxt == TAG_DATA) begin
              res_valid = 1'b1;
              res       = '{status: ST_DATA_FOUND, channels: ch_s, sample_rate: rate_s,
                            data_offset: pos_nxt, data_size: len_nxt};
              phase_nxt = PH_DONE;
            end else if (len_nxt != '0) begin
              skip_nxt  = len_nxt;
              phase_nxt = PH_SKIP;
            end
          end else begin
            idx_nxt = idx_s + 4'd1;
          end
        end
        PH_FMT: begin
          if (idx_s == IDX_CH_LO) begin
            ch_nxt[7:0] = b;
          end
          if (idx_s == IDX_CH_HI) begin
            ch_nxt[15:8] = b;
          end
          if (idx_s >= IDX_RATE_LO && idx_s <= IDX_RATE_HI) begin
            rate_nxt = set_lane(rate_s, idx_s[1:0], b);
          end
          if (idx_s >= IDX_FMT_LAST) begin
            idx_nxt = '0;
            if (len_s > FMT_BODY_LEN) begin
              skip_nxt  = len_s - FMT_BODY_LEN;
              phase_nxt = PH_SKIP;
            end else begin
              phase_nxt = PH_CHDR;
            end
          end else begin
            idx_nxt = idx_s + 4'd1;
          end
        end
        PH_SKIP: begin
          // down-count to zero, then back to chunk headers
          if (skip_s == '0 || skip_s == 32'd1) begin
            skip_nxt  = '0;
            idx_nxt   = '0;
            phase_nxt = PH_CHDR;
          end else begin
            skip_nxt = skip_dec;
          end
        end
        default: begin
          phase_nxt = PH_DONE;
        end
      endcase

      // early end unless this byte already produced a result
      if (item.end_of_file && !res_valid) begin
        res_valid  = 1'b1;
        res.status = ST_EARLY_END;
        phase_nxt  = PH_DONE;
      end
    end else if (!step) begin
      phase_nxt = phase_r;
      idx_nxt   = idx_r;
      pos_nxt   = pos_r;
      tag_nxt   = tag_r;
      len_nxt   = len_r;
      skip_nxt  = skip_r;
      ch_nxt    = ch_r;
      rate_nxt  = rate_r;
      bad_nxt   = bad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    pos_r  <= pos_nxt;
    tag_r  <= tag_nxt;
    len_r  <= len_nxt;
    skip_r <= skip_nxt;
    ch_r   <= ch_nxt;
    rate_r <= rate_nxt;
    bad_r  <= bad_nxt;
  end

endmodule

// ===== rtl/core/rwh_out_reg.sv =====
// result register presenting one result item to the receiver
module rwh_out_reg
  import rwh_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t load_res,
  input  logic    out_stall,
  output logic    out_valid,
  output logic    free,
  output result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign out_valid = valid_r;
  assign out_res   = res_r;
  assign free      = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

endmodule
